>>> design/fsd_pkg.sv
// Shared types, constants and quantizer helpers for the RGB332 dither core.
package fsd_pkg;

	// Geometry
	localparam int MAX_ROW_WIDTH = 80;
	localparam int COL_W         = $clog2(MAX_ROW_WIDTH);
	localparam int CNT_W         = $clog2(MAX_ROW_WIDTH + 1);
	localparam int WIDTH_W       = 7;
	localparam int CMP_W         = (CNT_W > WIDTH_W) ? CNT_W : WIDTH_W;
	localparam logic [WIDTH_W-1:0] ROW_WIDTH_RESET = WIDTH_W'(80);

	// Datapath widths
	localparam int PIX_W   = 8;
	localparam int ERR_W   = 12;  // accumulated error, sixteenths
	localparam int FRAC_W  = 4;   // divide by 16
	localparam int E_W     = 7;   // per-pixel quantization error, 0..84
	localparam int CARRY_W = 10;  // 7 * error
	localparam int LVL_W   = 3;

	// Quantizer
	localparam int FULL_SCALE = 255;
	localparam int RG_LEVELS  = 7;
	localparam int B_LEVELS   = 3;
	localparam int PROD_W     = 11;

	localparam logic [PIX_W-1:0] RG_EXPAND [RG_LEVELS+1] =
		'{8'd0, 8'd36, 8'd72, 8'd109, 8'd145, 8'd182, 8'd218, 8'd255};
	localparam logic [PIX_W-1:0] B_EXPAND [B_LEVELS+1] =
		'{8'd0, 8'd85, 8'd170, 8'd255};

	typedef enum logic {
		LANE_RG,
		LANE_B
	} fsd_lane_kind_t;

	typedef struct packed {
		logic [PIX_W-1:0] red_in;
		logic [PIX_W-1:0] green_in;
		logic [PIX_W-1:0] blue_in;
		logic             image_start;
	} fsd_pixel_t;

	typedef struct packed {
		logic [PIX_W-1:0] red_out;
		logic [PIX_W-1:0] green_out;
		logic [PIX_W-1:0] blue_out;
		logic [PIX_W-1:0] packed_rgb332;
		logic             row_end;
	} fsd_result_t;

	// Per-pixel control handed from the top level to every lane
	typedef struct packed {
		logic             rd_en;
		logic [COL_W-1:0] rd_addr;
		logic             adv;
		logic [COL_W-1:0] x;
		logic             last;
		logic             nop;
		logic [COL_W-1:0] prev_last;
	} fsd_ctl_t;

	typedef struct packed {
		logic [LVL_W-1:0] level;
		logic [PIX_W-1:0] value;
	} fsd_lane_out_t;

	// floor(7*v/255): count thresholds with 7*v >= 255*k
	function automatic logic [LVL_W-1:0] rg_level(input logic [PIX_W-1:0] v);
		logic [LVL_W-1:0] n;
		n = '0;
		for (int k = 1; k <= RG_LEVELS; k++) begin
			if (PROD_W'(v) * PROD_W'(RG_LEVELS) >= PROD_W'(FULL_SCALE * k))
				n = n + LVL_W'(1);
		end
		return n;
	endfunction

	// floor(3*v/255)
	function automatic logic [LVL_W-1:0] b_level(input logic [PIX_W-1:0] v);
		logic [LVL_W-1:0] n;
		n = '0;
		for (int k = 1; k <= B_LEVELS; k++) begin
			if (PROD_W'(v) * PROD_W'(B_LEVELS) >= PROD_W'(FULL_SCALE * k))
				n = n + LVL_W'(1);
		end
		return n;
	endfunction

endpackage

>>> design/fsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem_q[rd_addr];
	end

endmodule

>>> design/fsd_lane.sv
// One color channel: error gather, quantize, and diffusion into the line store.
module fsd_lane (
	input  logic                         clk,
	input  fsd_pkg::fsd_lane_kind_t      kind,
	input  fsd_pkg::fsd_ctl_t            ctl,
	input  logic [fsd_pkg::PIX_W-1:0]    pix,
	output fsd_pkg::fsd_lane_out_t       lane_out
);

	logic                          wr_en;
	logic [fsd_pkg::COL_W-1:0]     wr_addr;
	logic [fsd_pkg::ERR_W-1:0]     wr_data;
	logic [fsd_pkg::ERR_W-1:0]     rd_data;

	logic                          byp_hit_s1;
	logic [fsd_pkg::ERR_W-1:0]     byp_data_s1;

	logic [fsd_pkg::CARRY_W-1:0]   carry_q;
	logic [fsd_pkg::ERR_W-1:0]     pend_prev_q;
	logic [fsd_pkg::E_W-1:0]       pend_cur_q;
	logic [fsd_pkg::ERR_W-1:0]     tail0_q;
	logic [fsd_pkg::E_W-1:0]       tail1_q;

	logic [fsd_pkg::ERR_W-1:0]     mem_val;
	logic [fsd_pkg::CNT_W-1:0]     x_ext;
	logic [fsd_pkg::CNT_W-1:0]     pl_ext;
	logic [fsd_pkg::ERR_W-1:0]     below;
	logic [fsd_pkg::ERR_W-1:0]     err_sum;
	logic [fsd_pkg::PIX_W:0]       v_sum;
	logic [fsd_pkg::PIX_W-1:0]     v;
	logic [fsd_pkg::LVL_W-1:0]     level;
	logic [fsd_pkg::PIX_W-1:0]     value;
	logic [fsd_pkg::E_W-1:0]       e;
	logic [fsd_pkg::ERR_W-1:0]     e_ext;
	logic [fsd_pkg::ERR_W-1:0]     pend_next;
	logic [fsd_pkg::CARRY_W-1:0]   carry_next;

	fsd_ram #(
		.WIDTH(fsd_pkg::ERR_W),
		.DEPTH(fsd_pkg::MAX_ROW_WIDTH)
	) u_line (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (ctl.rd_en),
		.rd_addr(ctl.rd_addr),
		.rd_data(rd_data)
	);

	// RAM reads old data; catch a same-edge write to the address being fetched
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			byp_hit_s1  <= wr_en && (wr_addr == ctl.rd_addr);
			byp_data_s1 <= wr_data;
		end
	end

	assign mem_val = byp_hit_s1 ? byp_data_s1 : rd_data;
	assign x_ext   = fsd_pkg::CNT_W'(ctl.x);
	assign pl_ext  = fsd_pkg::CNT_W'(ctl.prev_last);

	// Entries below the last pixel of the previous row live in the RAM,
	// the last two in tail registers, anything further was never written.
	always_comb begin
		if (ctl.nop)
			below = '0;
		else if (x_ext < pl_ext)
			below = mem_val;
		else if (x_ext == pl_ext)
			below = tail0_q;
		else if (x_ext == pl_ext + fsd_pkg::CNT_W'(1))
			below = fsd_pkg::ERR_W'(tail1_q);
		else
			below = '0;
	end

	assign err_sum = below + ((ctl.x != '0) ? fsd_pkg::ERR_W'(carry_q) : '0);
	assign v_sum   = {1'b0, pix}
		+ (fsd_pkg::PIX_W+1)'(err_sum[fsd_pkg::ERR_W-1:fsd_pkg::FRAC_W]);
	assign v       = v_sum[fsd_pkg::PIX_W] ? '1 : v_sum[fsd_pkg::PIX_W-1:0];

	always_comb begin
		unique case (kind)
			fsd_pkg::LANE_RG: begin
				level = fsd_pkg::rg_level(v);
				value = fsd_pkg::RG_EXPAND[level];
			end
			fsd_pkg::LANE_B: begin
				level = fsd_pkg::b_level(v);
				value = fsd_pkg::B_EXPAND[level[1:0]];
			end
		endcase
	end

	// floor quantizer, so the error is never negative
	assign e     = fsd_pkg::E_W'(v - value);
	assign e_ext = fsd_pkg::ERR_W'(e);

	// 3/16 lower-left closes entry x-1; 5/16 and 1/16 stay pending
	assign wr_en      = ctl.adv && (ctl.x != '0);
	assign wr_addr    = ctl.x - fsd_pkg::COL_W'(1);
	assign wr_data    = pend_prev_q + (e_ext << 1) + e_ext;
	assign pend_next  = ((ctl.x != '0) ? fsd_pkg::ERR_W'(pend_cur_q) : '0)
		+ (e_ext << 2) + e_ext;
	assign carry_next = fsd_pkg::CARRY_W'({e, 3'b000}) - fsd_pkg::CARRY_W'(e);

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			carry_q     <= carry_next;
			pend_prev_q <= pend_next;
			pend_cur_q  <= e;
			if (ctl.last) begin
				tail0_q <= pend_next;
				tail1_q <= e;
			end
		end
	end

	assign lane_out.level = level;
	assign lane_out.value = value;

endmodule

>>> design/fsd_merge.sv
// Output register: combines the three lanes into one result and packs 3:3:2.
module fsd_merge (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  logic                      row_end,
	input  fsd_pkg::fsd_lane_out_t    red_lane,
	input  fsd_pkg::fsd_lane_out_t    green_lane,
	input  fsd_pkg::fsd_lane_out_t    blue_lane,
	output logic                      result_valid,
	input  logic                      result_ready,
	output fsd_pkg::fsd_result_t      result
);

	logic                 valid_q;
	fsd_pkg::fsd_result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q.red_out       <= red_lane.value;
			result_q.green_out     <= green_lane.value;
			result_q.blue_out      <= blue_lane.value;
			result_q.packed_rgb332 <= {red_lane.level, green_lane.level,
				blue_lane.level[1:0]};
			result_q.row_end       <= row_end;
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

endmodule

>>> design/floyd_steinberg_dither_rgb332_core.sv
// Top level of the Floyd-Steinberg RGB888 to RGB332 dither core.
// Takes one RGB888 pixel per clock in raster order while pixel_ready is
// high and returns one dithered pixel per input: the three channel values
// expanded back to 8 bits, the packed 3:3:2 byte and a row_end flag.
// Throughput is one pixel per clock while the output is not stalled; a
// transferred pixel waits in the compute stage until the output register
// is free or being drained. The rate is set by the right-neighbor error
// loop in each channel lane (gather, divide by 16, clamp, quantize, 7/16
// feedback), which closes combinationally around the carry register. Three
// lanes (red, green, blue) run side by side and an output register merges
// them. Each lane keeps the next row's error in a line RAM of MAX_ROW_WIDTH
// entries with registered read; the read is issued at the pixel transfer,
// so the RAM port sets the stage ahead of the output register. The last
// two entries of each row sit in tail registers, and a tracked previous-row
// end stands in for clearing, so there is no clearing pass after reset or
// at image start. row_width is written through the cfg port (always ready)
// and must only change while no pixel is in flight; 0 acts as 1 and values
// above MAX_ROW_WIDTH act as MAX_ROW_WIDTH.
module floyd_steinberg_dither_rgb332_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fsd_pkg::WIDTH_W-1:0]    cfg_data,
	input  logic                           pixel_valid,
	output logic                           pixel_ready,
	input  fsd_pkg::fsd_pixel_t            pixel,
	output logic                           result_valid,
	input  logic                           result_ready,
	output fsd_pkg::fsd_result_t           result
);

	logic [fsd_pkg::WIDTH_W-1:0]   row_width_q;
	logic [fsd_pkg::CMP_W-1:0]     rw_ext;
	logic [fsd_pkg::CMP_W-1:0]     w_eff;

	// Position tracking, advanced at each pixel transfer
	logic [fsd_pkg::COL_W-1:0]     col_q;
	logic                          nop_q;     // current row has no row above
	logic                          accept;
	logic [fsd_pkg::COL_W-1:0]     x_acc;
	logic                          nop_acc;
	logic                          last_acc;

	// Compute stage
	logic                          valid_s1;
	fsd_pkg::fsd_pixel_t           pixel_s1;
	logic [fsd_pkg::COL_W-1:0]     x_s1;
	logic                          last_s1;
	logic                          nop_s1;
	logic                          adv;
	logic [fsd_pkg::COL_W-1:0]     prev_last_q;

	fsd_pkg::fsd_ctl_t             ctl;
	fsd_pkg::fsd_lane_out_t        red_lane;
	fsd_pkg::fsd_lane_out_t        green_lane;
	fsd_pkg::fsd_lane_out_t        blue_lane;

	// Config register, written whenever a transfer happens
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= fsd_pkg::ROW_WIDTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			row_width_q <= cfg_data;
		end
	end

	// Effective width: clamp to 1..MAX_ROW_WIDTH
	assign rw_ext = fsd_pkg::CMP_W'(row_width_q);

	always_comb begin
		if (rw_ext == '0)
			w_eff = fsd_pkg::CMP_W'(1);
		else if (rw_ext > fsd_pkg::CMP_W'(fsd_pkg::MAX_ROW_WIDTH))
			w_eff = fsd_pkg::CMP_W'(fsd_pkg::MAX_ROW_WIDTH);
		else
			w_eff = rw_ext;
	end

	// Flow control: s1 moves into the output register when it is free
	// or being drained, so a new pixel enters behind a waiting result.
	assign adv         = valid_s1 && (!result_valid || result_ready);
	assign pixel_ready = !valid_s1 || adv;
	assign accept      = pixel_valid && pixel_ready;

	// Image start restarts the column and drops the row above
	assign x_acc    = pixel.image_start ? '0 : col_q;
	assign nop_acc  = pixel.image_start || nop_q;
	assign last_acc = (fsd_pkg::CMP_W'(x_acc) + fsd_pkg::CMP_W'(1)) >= w_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			nop_q <= 1'b1;
		end else if (accept) begin
			col_q <= last_acc ? '0 : x_acc + fsd_pkg::COL_W'(1);
			nop_q <= last_acc ? 1'b0 : nop_acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= pixel;
			x_s1     <= x_acc;
			last_s1  <= last_acc;
			nop_s1   <= nop_acc;
		end
	end

	// Column of the last pixel of the finished row; selects RAM vs tails
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_last_q <= '0;
		end else if (adv && last_s1) begin
			prev_last_q <= x_s1;
		end
	end

	always_comb begin
		ctl.rd_en     = accept;
		ctl.rd_addr   = x_acc;
		ctl.adv       = adv;
		ctl.x         = x_s1;
		ctl.last      = last_s1;
		ctl.nop       = nop_s1;
		ctl.prev_last = prev_last_q;
	end

	fsd_lane u_red (
		.clk     (clk),
		.kind    (fsd_pkg::LANE_RG),
		.ctl     (ctl),
		.pix     (pixel_s1.red_in),
		.lane_out(red_lane)
	);

	fsd_lane u_green (
		.clk     (clk),
		.kind    (fsd_pkg::LANE_RG),
		.ctl     (ctl),
		.pix     (pixel_s1.green_in),
		.lane_out(green_lane)
	);

	fsd_lane u_blue (
		.clk     (clk),
		.kind    (fsd_pkg::LANE_B),
		.ctl     (ctl),
		.pix     (pixel_s1.blue_in),
		.lane_out(blue_lane)
	);

	fsd_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (adv),
		.row_end     (last_s1),
		.red_lane    (red_lane),
		.green_lane  (green_lane),
		.blue_lane   (blue_lane),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

endmodule

>>> design/fsd_checker.sv
// Port-level checks for the dither core, bound to the top level.
module fsd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           pixel_valid,
	input logic                           pixel_ready,
	input logic                           result_valid,
	input logic                           result_ready,
	input fsd_pkg::fsd_result_t           result
);

	// A stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// With the output register empty the input side never stalls
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> pixel_ready)
		else $error("pixel stalled with empty output");

	// A fresh result comes from an earlier pixel transfer, via the compute stage
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(pixel_valid && pixel_ready, 2))
		else $error("result without matching pixel transfer");

	// One pixel buffered behind a stalled result fills the core
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && pixel_ready && result_valid && !result_ready
		|=> result_ready || !pixel_ready)
		else $error("core accepted beyond its buffering");

endmodule

bind floyd_steinberg_dither_rgb332_core fsd_checker u_fsd_checker (.*);

>>> verif/testbench.sv
// Self-checking testbench for the Floyd-Steinberg RGB332 dither core.
module testbench;
	import fsd_pkg::*;

	// Clock period, reset length and run limits
	localparam int CLK_PERIOD    = 12;
	localparam int RESET_CYCLES  = 4;
	localparam int SETTLE_CYCLES = 6;     // idle wait after the result queue drains
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_PIXELS = 400;
	localparam int MAX_REPORTS   = 10;

	// Channel slots in the error store
	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;
	localparam int NUM_CH   = 3;
	localparam int ROW_SLOTS = MAX_ROW_WIDTH + 1;  // one slack entry past the row end

	// Directed stimulus rows: either a pixel transfer or a row_width write
	typedef enum logic {
		STEP_PIXEL,
		STEP_WIDTH
	} step_kind_t;

	typedef struct packed {
		step_kind_t           kind;
		logic [WIDTH_W-1:0]   width;
		fsd_pixel_t           px;
		logic                 known;  // res below is typed in, not predicted
		fsd_result_t          res;
	} directed_step_t;

	localparam int NUM_STEPS = 29;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                cfg_valid    = 1'b0;
	logic                cfg_ready;
	logic [WIDTH_W-1:0]  cfg_data     = '0;
	logic                pixel_valid  = 1'b0;
	logic                pixel_ready;
	fsd_pixel_t          pixel        = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	fsd_result_t         result;

	// Dither model state: two row buffers of accumulated error per channel
	int unsigned         err_acc [2][NUM_CH][ROW_SLOTS];
	int unsigned         col_pos;
	int unsigned         row_sel;
	logic [WIDTH_W-1:0]  row_width_cfg = ROW_WIDTH_RESET;

	fsd_result_t         expected_results [$];
	int unsigned         mismatch_count = 0;
	int unsigned         cycle_count    = 0;
	int unsigned         burst_left     = 0;
	int unsigned         stall_left     = 0;
	int unsigned         stall_mode     = 0;

	directed_step_t      plan [NUM_STEPS];

	floyd_steinberg_dither_rgb332_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ---------------------------------------------------------------
	// Dither model
	// ---------------------------------------------------------------

	function automatic void clear_error_rows(input bit both, input int unsigned which);
		for (int r = 0; r < 2; r++) begin
			for (int c = 0; c < NUM_CH; c++) begin
				for (int k = 0; k < ROW_SLOTS; k++) begin
					if (both || r == which)
						err_acc[r][c][k] = 0;
				end
			end
		end
	endfunction

	// Add the carried error, clamp, quantize, then push the new error out:
	// 7/16 right in this row, 3/16, 5/16, 1/16 into the row below.
	function automatic logic [PIX_W-1:0] quantize_channel(input int ch,
			input fsd_lane_kind_t kind, input logic [PIX_W-1:0] pix,
			input int unsigned x, input int unsigned cur, output logic [LVL_W-1:0] level);
		int levels;
		int v;
		int q;
		int expanded;
		int e_val;
		int unsigned nxt;
		levels = (kind == LANE_RG) ? RG_LEVELS : B_LEVELS;
		nxt = cur ^ 1;
		v = int'(pix) + int'(err_acc[cur][ch][x] / 16);
		if (v > FULL_SCALE)
			v = FULL_SCALE;
		else if (v < 0)
			v = 0;
		q = levels * v / FULL_SCALE;
		expanded = FULL_SCALE * q / levels;
		e_val = v - expanded;  // never negative: expanded rounds down
		err_acc[cur][ch][x + 1] += 7 * e_val;
		if (x > 0)
			err_acc[nxt][ch][x - 1] += 3 * e_val;
		err_acc[nxt][ch][x] += 5 * e_val;
		err_acc[nxt][ch][x + 1] += e_val;
		level = LVL_W'(q);
		return PIX_W'(expanded);
	endfunction

	function automatic fsd_result_t dither_step(input fsd_pixel_t px);
		fsd_result_t r;
		int unsigned w;
		int unsigned x;
		int unsigned cur;
		logic [LVL_W-1:0] lr;
		logic [LVL_W-1:0] lg;
		logic [LVL_W-1:0] lb;
		// 0 acts as 1, anything past the buffer acts as full width
		w = row_width_cfg;
		if (w < 1)
			w = 1;
		if (w > MAX_ROW_WIDTH)
			w = MAX_ROW_WIDTH;
		if (px.image_start) begin
			clear_error_rows(1'b1, 0);
			col_pos = 0;
			row_sel = 0;
		end
		if (col_pos >= MAX_ROW_WIDTH)
			col_pos = MAX_ROW_WIDTH - 1;
		x = col_pos;
		cur = row_sel & 1;
		// New row: the buffer for the row below starts out clean
		if (x == 0)
			clear_error_rows(1'b0, cur ^ 1);
		r.red_out   = quantize_channel(CH_RED, LANE_RG, px.red_in, x, cur, lr);
		r.green_out = quantize_channel(CH_GREEN, LANE_RG, px.green_in, x, cur, lg);
		r.blue_out  = quantize_channel(CH_BLUE, LANE_B, px.blue_in, x, cur, lb);
		r.packed_rgb332 = {lr, lg, lb[1:0]};
		// A width shrunk mid-row ends the row at the next pixel
		r.row_end = (x + 1 >= w);
		if (r.row_end) begin
			col_pos = 0;
			row_sel = cur ^ 1;
		end else begin
			col_pos = x + 1;
		end
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Directed table helpers
	// ---------------------------------------------------------------

	function automatic fsd_pixel_t pixel_of(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic s);
		fsd_pixel_t p;
		p.red_in = r;
		p.green_in = g;
		p.blue_in = b;
		p.image_start = s;
		return p;
	endfunction

	function automatic directed_step_t pixel_step(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic s);
		directed_step_t d;
		d = '0;
		d.kind = STEP_PIXEL;
		d.px = pixel_of(r, g, b, s);
		return d;
	endfunction

	// Pixel whose result is obvious: flat error store, extremes or clear start
	function automatic directed_step_t known_step(input fsd_pixel_t p, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b, input logic [7:0] pk, input logic e);
		directed_step_t d;
		d = '0;
		d.kind = STEP_PIXEL;
		d.px = p;
		d.known = 1'b1;
		d.res.red_out = r;
		d.res.green_out = g;
		d.res.blue_out = b;
		d.res.packed_rgb332 = pk;
		d.res.row_end = e;
		return d;
	endfunction

	function automatic directed_step_t width_step(input logic [WIDTH_W-1:0] w);
		directed_step_t d;
		d = '0;
		d.kind = STEP_WIDTH;
		d.width = w;
		return d;
	endfunction

	// Biased toward the clamp edges so saturation gets hit often
	function automatic logic [7:0] random_channel();
		int unsigned pick;
		pick = $urandom_range(0, 7);
		if (pick == 0)
			return 8'd0;
		if (pick == 1)
			return 8'd255;
		return 8'($urandom_range(0, 255));
	endfunction

	// ---------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------

	// Pixel sender: bursts of random length with random gaps, some gapless.
	// On return we sit on the edge of the transfer; the model is stepped and
	// the expectation queued there.
	task automatic send_pixel(input fsd_pixel_t px, input logic known,
			input fsd_result_t typed_res);
		int unsigned gap;
		fsd_result_t predicted;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			burst_left = $urandom_range(1, 24);
			if (gap != 0) begin
				pixel_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		pixel_valid <= 1'b1;
		pixel <= px;
		@(posedge clk);
		while (!pixel_ready)
			@(posedge clk);
		predicted = dither_step(px);
		expected_results.push_back(known ? typed_res : predicted);
	endtask

	// row_width is only touched with the pipe empty
	task automatic write_width(input logic [WIDTH_W-1:0] w);
		pixel_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= w;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		row_width_cfg = w;
	endtask

	// Receiver: stall behavior switches between always ready, coin flip,
	// and mostly stalled, each held for a random stretch
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(10, 60);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: begin
				result_ready <= 1'b1;
			end
			1: begin
				result_ready <= ($urandom_range(0, 1) == 1);
			end
			default: begin
				result_ready <= ($urandom_range(0, 3) == 0);
			end
		endcase
	end

	// ---------------------------------------------------------------
	// Result checking
	// ---------------------------------------------------------------

	task automatic flag_mismatch(input string what, input fsd_result_t want,
			input fsd_result_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t %s: expected r=%0d g=%0d b=%0d rgb332=%02h end=%0b, got r=%0d g=%0d b=%0d rgb332=%02h end=%0b",
				$time, what, want.red_out, want.green_out, want.blue_out,
				want.packed_rgb332, want.row_end, got.red_out, got.green_out,
				got.blue_out, got.packed_rgb332, got.row_end);
	endtask

	always @(posedge clk) begin
		fsd_result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				flag_mismatch("result with no pixel pending", '0, result);
			end else begin
				want = expected_results.pop_front();
				if (result.red_out !== want.red_out ||
						result.green_out !== want.green_out ||
						result.blue_out !== want.blue_out ||
						result.packed_rgb332 !== want.packed_rgb332 ||
						result.row_end !== want.row_end)
					flag_mismatch("dithered pixel mismatch", want, result);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("floyd_steinberg_dither_rgb332_core test failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------

	initial begin
		int unsigned sent;
		int unsigned pick;
		int unsigned eff_w;
		int unsigned count;
		logic [WIDTH_W-1:0] w;
		bit fresh;
		bit first_phase;
		fsd_pixel_t px;

		plan = '{
			// extremes from a clean store; width 80 after reset
			known_step(pixel_of(8'd0, 8'd0, 8'd0, 1'b1), 8'd0, 8'd0, 8'd0, 8'h00, 1'b0),
			known_step(pixel_of(8'd255, 8'd255, 8'd255, 1'b1),
				8'd255, 8'd255, 8'd255, 8'hFF, 1'b0),
			known_step(pixel_of(8'd255, 8'd0, 8'd255, 1'b0),
				8'd255, 8'd0, 8'd255, 8'hE3, 1'b0),
			known_step(pixel_of(8'd0, 8'd255, 8'd0, 1'b0), 8'd0, 8'd255, 8'd0, 8'h1C, 1'b0),
			known_step(pixel_of(8'd128, 8'd128, 8'd128, 1'b1),
				8'd109, 8'd109, 8'd85, 8'h6D, 1'b0),
			pixel_step(8'd128, 8'd128, 8'd128, 1'b0),
			pixel_step(8'd200, 8'd30, 8'd90, 1'b0),
			// one pixel per row: every pixel ends its row
			width_step(WIDTH_W'(1)),
			known_step(pixel_of(8'd255, 8'd255, 8'd255, 1'b1),
				8'd255, 8'd255, 8'd255, 8'hFF, 1'b1),
			pixel_step(8'd100, 8'd150, 8'd250, 1'b0),
			pixel_step(8'd1, 8'd2, 8'd3, 1'b0),
			// zero width behaves as one
			width_step(WIDTH_W'(0)),
			known_step(pixel_of(8'd0, 8'd0, 8'd0, 1'b1), 8'd0, 8'd0, 8'd0, 8'h00, 1'b1),
			pixel_step(8'd37, 8'd219, 8'd171, 1'b0),
			// register maximum, clipped to the buffer size
			width_step(WIDTH_W'(127)),
			pixel_step(8'd254, 8'd1, 8'd127, 1'b1),
			pixel_step(8'd60, 8'd60, 8'd60, 1'b0),
			// narrow rows, restart mid-row, then shrink the width mid-row
			width_step(WIDTH_W'(3)),
			pixel_step(8'd170, 8'd85, 8'd240, 1'b1),
			pixel_step(8'd15, 8'd240, 8'd130, 1'b0),
			pixel_step(8'd90, 8'd90, 8'd90, 1'b1),
			pixel_step(8'd250, 8'd5, 8'd66, 1'b0),
			width_step(WIDTH_W'(2)),
			pixel_step(8'd33, 8'd177, 8'd201, 1'b0),
			pixel_step(8'd128, 8'd64, 8'd32, 1'b0),
			pixel_step(8'd255, 8'd128, 8'd0, 1'b0),
			// one past the buffer size
			width_step(WIDTH_W'(81)),
			pixel_step(8'd77, 8'd88, 8'd99, 1'b1),
			pixel_step(8'd0, 8'd255, 8'd255, 1'b0)
		};

		clear_error_rows(1'b1, 0);
		col_pos = 0;
		row_sel = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == STEP_WIDTH)
				write_width(plan[i].width);
			else
				send_pixel(plan[i].px, plan[i].known, plan[i].res);
		end

		// Random part: phases of one width each. Most phases open a new image
		// and run at least one full row; a few carry on the old image across the
		// width change, and a stray image_start now and then restarts mid-row.
		sent = 0;
		first_phase = 1'b1;
		while (sent < RANDOM_PIXELS) begin
			pick = $urandom_range(0, 9);
			if (first_phase)
				w = WIDTH_W'(MAX_ROW_WIDTH);
			else if (pick == 0)
				w = WIDTH_W'(MAX_ROW_WIDTH);
			else if (pick == 1)
				w = '0;
			else if (pick == 2)
				w = WIDTH_W'($urandom_range(MAX_ROW_WIDTH + 1, 127));
			else if (pick == 3)
				w = WIDTH_W'(1);
			else
				w = WIDTH_W'($urandom_range(2, 12));
			first_phase = 1'b0;
			write_width(w);

			eff_w = (w == 0) ? 1 : ((w > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH : w);
			fresh = ($urandom_range(0, 4) != 0);
			if (eff_w >= MAX_ROW_WIDTH)
				count = $urandom_range(MAX_ROW_WIDTH, 2 * MAX_ROW_WIDTH + 10);
			else
				count = $urandom_range(3 * eff_w, 4 * eff_w + 12);

			for (int k = 0; k < count; k++) begin
				px.red_in = random_channel();
				px.green_in = random_channel();
				px.blue_in = random_channel();
				px.image_start = (k == 0 && fresh) || ($urandom_range(0, 39) == 0);
				send_pixel(px, 1'b0, '0);
				sent++;
			end
		end

		pixel_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("floyd_steinberg_dither_rgb332_core test passed");
		else
			$display("floyd_steinberg_dither_rgb332_core test failed");
		$finish;
	end

endmodule

>>> floyd_steinberg_dither_rgb332_core.f
design/fsd_pkg.sv
design/fsd_ram.sv
design/fsd_lane.sv
design/fsd_merge.sv
design/floyd_steinberg_dither_rgb332_core.sv
design/fsd_checker.sv
verif/testbench.sv
